>>> rtl/assert_macros.svh
// Assertion macros for the snapshot-recall RTL, used by mcsr_back.
// Relies on signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/mcsr_pkg.sv
// Package for the MIDI CC snapshot-recall block: sizes, codes and word types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mcsr_pkg;

    localparam int NUM_CHANNELS    = 16;
    localparam int NUM_CONTROLLERS = 128;
    localparam int TABLE_SIZE      = NUM_CHANNELS * NUM_CONTROLLERS;

    localparam int TABLE_BITS = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int LEN_BITS   = TABLE_BITS + 1;
    localparam int CHAN_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CTRL_BITS  = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STATUS_CC     = 8'hB0;
    localparam logic [7:0] TYPE_MASK     = 8'hF0;
    localparam logic [7:0] EMPTY_ENTRY   = 8'd129;
    localparam logic [7:0] NO_VALUE_SENT = 8'h80;

    // Input command codes
    localparam logic [2:0] CMD_MESSAGE        = 3'd0;
    localparam logic [2:0] CMD_TRIGGER        = 3'd1;
    localparam logic [2:0] CMD_TRIGGER_PRESET = 3'd2;
    localparam logic [2:0] CMD_CLEAR          = 3'd3;
    localparam logic [2:0] CMD_TICK           = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_LISTEN_CHANNEL   = 2'd0;
    localparam logic [1:0] REG_CAPTURE_ENABLE   = 2'd1;
    localparam logic [1:0] REG_THRU_ENABLE      = 2'd2;
    localparam logic [1:0] REG_BLOCK_DUPLICATES = 2'd3;

    // Back-end operation kinds
    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_NONE  = 2'd0;
    localparam op_kind_t OP_STORE = 2'd1;
    localparam op_kind_t OP_CHECK = 2'd2;
    localparam op_kind_t OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [4:0] listen_channel;
        logic       capture_enable;
        logic       thru_enable;
        logic       block_duplicates;
    } cfg_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_status;
        logic [7:0] out_data_one;
        logic [7:0] out_data_two;
        logic       from_replay;
        logic       replay_done;
    } res_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [TABLE_BITS-1:0] idx;
        logic [6:0]            value;
        logic                  wr_last;
        logic                  dedup;
        res_t                  res;
    } op_t;

endpackage

`default_nettype wire

>>> rtl/midi_cc_snapshot_recall.sv
// MIDI CC snapshot-recall: captures control change values per channel and
// controller, passes messages through, and replays the snapshot one tick at a time.
// Top level; depends on mcsr_pkg, mcsr_front, mcsr_op_queue, mcsr_back, mcsr_res_queue.
//
// Both sides look like queues. A word goes in when push is high and full is low,
// and every word gives exactly one result word, taken when pop is high and empty
// is low. After reset the block sweeps both tables to their reset contents: full
// stays high during the sweep (one table entry per cycle), while configuration
// writes are taken as usual. The front end classifies one word per cycle, while
// full is low, into a two-deep operation queue; the back end then finishes a
// message, trigger, unknown command or idle tick in its idle state, and a live
// replay tick in idle and evaluate (table read, then compare and last-sent write
// through the single port of each table). A clear walks the value table one entry
// per cycle, during which the queue keeps filling until full. Results leave through
// a two-deep queue, so a stalled reader holds the back end as soon as that queue is
// full, and holds the input once the operation queue has filled behind it. A result
// is registered in both queues; a replay tick also passes the table read registers.
`default_nettype none

module midi_cc_snapshot_recall
    import mcsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_addr,
    input  wire logic [4:0] cfg_wdata,
    // input word
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] command,
    input  wire logic [7:0] status_byte,
    input  wire logic [7:0] data_one,
    input  wire logic [7:0] data_two,
    // result word
    output logic            empty,
    input  wire logic       pop,
    output logic            out_valid,
    output logic [7:0]      out_status,
    output logic [7:0]      out_data_one,
    output logic [7:0]      out_data_two,
    output logic            from_replay,
    output logic            replay_done
);

    cfg_t cfg_reg;
    logic take;
    op_t  front_op;
    logic op_full;
    logic op_empty;
    op_t  op_head;
    logic op_pop;
    logic res_full;
    logic res_push;
    res_t res_word;
    res_t res_head;
    logic init_busy;

    // Configuration registers; to be written by the user only while the block is idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.listen_channel   <= 5'd0;
            cfg_reg.capture_enable   <= 1'b1;
            cfg_reg.thru_enable      <= 1'b1;
            cfg_reg.block_duplicates <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LISTEN_CHANNEL:   cfg_reg.listen_channel   <= cfg_wdata;
                REG_CAPTURE_ENABLE:   cfg_reg.capture_enable   <= cfg_wdata[0];
                REG_THRU_ENABLE:      cfg_reg.thru_enable      <= cfg_wdata[0];
                REG_BLOCK_DUPLICATES: cfg_reg.block_duplicates <= cfg_wdata[0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Hold off input while the operation queue is full and until the table sweep after reset is done
    assign full = op_full || init_busy;
    assign take = push && !full;

    mcsr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .take        (take),
        .command     (command),
        .status_byte (status_byte),
        .data_one    (data_one),
        .data_two    (data_two),
        .op          (front_op)
    );

    mcsr_op_queue u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (front_op),
        .full      (op_full),
        .pop       (op_pop),
        .pop_data  (op_head),
        .empty     (op_empty)
    );

    mcsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_data   (op_head),
        .op_pop    (op_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_word),
        .init_busy (init_busy)
    );

    mcsr_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_word),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_head),
        .empty     (empty)
    );

    assign out_valid    = res_head.out_valid;
    assign out_status   = res_head.out_status;
    assign out_data_one = res_head.out_data_one;
    assign out_data_two = res_head.out_data_two;
    assign from_replay  = res_head.from_replay;
    assign replay_done  = res_head.replay_done;

endmodule

`default_nettype wire

>>> rtl/mcsr_op_queue.sv
// Short first-word-fall-through queue of operation words, front to back.
// Depends on mcsr_pkg.
`default_nettype none

module mcsr_op_queue
    import mcsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_data,
    output logic      full,
    input  wire logic pop,
    output op_t       pop_data,
    output logic      empty
);

    op_t                  slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mcsr_res_queue.sv
// Short first-word-fall-through queue of result words on the output side.
// Depends on mcsr_pkg.
`default_nettype none

module mcsr_res_queue
    import mcsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  res_t      push_data,
    output logic      full,
    input  wire logic pop,
    output res_t      pop_data,
    output logic      empty
);

    res_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mcsr_front.sv
// Front end: classifies each accepted word and keeps the replay sweep state.
// Depends on mcsr_pkg; feeds mcsr_op_queue.
`default_nettype none

module mcsr_front
    import mcsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  cfg_t            cfg,
    input  wire logic       take,
    input  wire logic [2:0] command,
    input  wire logic [7:0] status_byte,
    input  wire logic [7:0] data_one,
    input  wire logic [7:0] data_two,
    output op_t             op
);

    logic                  active_reg, active_next;
    logic                  dedup_reg, dedup_next;
    logic [TABLE_BITS-1:0] ptr_reg, ptr_next;
    logic [CHAN_BITS-1:0]  chan_cnt_reg, chan_cnt_next;
    logic [CTRL_BITS-1:0]  ctrl_cnt_reg, ctrl_cnt_next;

    logic [4:0]            msg_chan;
    logic                  capture_hit;
    logic [TABLE_BITS-1:0] msg_idx;
    logic                  all_channels;
    logic [LEN_BITS-1:0]   sweep_len;
    logic [LEN_BITS-1:0]   ptr_ext;
    logic                  last_entry;
    logic                  in_range;
    logic [CHAN_BITS-1:0]  chan_sel;
    logic [CTRL_BITS-1:0]  ctrl_sel;
    logic [TABLE_BITS-1:0] tick_idx;

    // Message classification
    always_comb
    begin
        msg_chan    = {1'b0, status_byte[3:0]} + 5'd1;
        capture_hit = ((cfg.listen_channel == 5'd0) || (msg_chan == cfg.listen_channel))
                      && ((status_byte & TYPE_MASK) == STATUS_CC)
                      && cfg.capture_enable
                      && ({1'b0, status_byte[3:0]} < 5'(NUM_CHANNELS))
                      && ({1'b0, data_one[6:0]} < 8'(NUM_CONTROLLERS));
        msg_idx     = TABLE_BITS'(int'(status_byte[3:0]) * NUM_CONTROLLERS
                                  + int'(data_one[6:0]));
    end

    // Sweep position for the next tick
    always_comb
    begin
        all_channels = (cfg.listen_channel == 5'd0);
        sweep_len    = all_channels ? LEN_BITS'(TABLE_SIZE) : LEN_BITS'(NUM_CONTROLLERS);
        ptr_ext      = {1'b0, ptr_reg};
        last_entry   = (ptr_ext + 1'b1) >= sweep_len;
        in_range     = (all_channels || (cfg.listen_channel <= 5'(NUM_CHANNELS)))
                       && (ptr_ext < sweep_len);
        chan_sel     = all_channels ? chan_cnt_reg : CHAN_BITS'(cfg.listen_channel - 5'd1);
        ctrl_sel     = all_channels ? ctrl_cnt_reg : CTRL_BITS'(ptr_reg);
        tick_idx     = TABLE_BITS'(int'(chan_sel) * NUM_CONTROLLERS + int'(ctrl_sel));
    end

    always_comb
    begin
        op            = '0;
        op.kind       = OP_NONE;
        active_next   = active_reg;
        dedup_next    = dedup_reg;
        ptr_next      = ptr_reg;
        chan_cnt_next = chan_cnt_reg;
        ctrl_cnt_next = ctrl_cnt_reg;

        case (command)
            CMD_MESSAGE:
            begin
                op.kind    = capture_hit ? OP_STORE : OP_NONE;
                op.idx     = msg_idx;
                op.value   = data_two[6:0];
                op.wr_last = cfg.thru_enable;
                if (cfg.thru_enable)
                begin
                    op.res.out_valid    = 1'b1;
                    op.res.out_status   = status_byte;
                    op.res.out_data_one = data_one;
                    op.res.out_data_two = data_two;
                end
            end
            CMD_TRIGGER, CMD_TRIGGER_PRESET:
            begin
                active_next   = 1'b1;
                dedup_next    = (command == CMD_TRIGGER_PRESET);
                ptr_next      = '0;
                chan_cnt_next = '0;
                ctrl_cnt_next = '0;
            end
            CMD_CLEAR:
            begin
                op.kind = OP_CLEAR;
            end
            CMD_TICK:
            begin
                if (active_reg)
                begin
                    op.kind             = in_range ? OP_CHECK : OP_NONE;
                    op.idx              = tick_idx;
                    op.dedup            = cfg.block_duplicates && dedup_reg;
                    op.res.replay_done  = last_entry;
                    // Carry the replay address only when an entry is checked
                    if (in_range)
                    begin
                        op.res.out_status   = STATUS_CC | 8'(chan_sel);
                        op.res.out_data_one = 8'(ctrl_sel);
                    end
                    if (last_entry)
                    begin
                        active_next   = 1'b0;
                        dedup_next    = 1'b0;
                        ptr_next      = '0;
                        chan_cnt_next = '0;
                        ctrl_cnt_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                        if (ctrl_cnt_reg == CTRL_BITS'(NUM_CONTROLLERS - 1))
                        begin
                            ctrl_cnt_next = '0;
                            chan_cnt_next = chan_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ctrl_cnt_next = ctrl_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                op.kind = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            dedup_reg    <= 1'b0;
            ptr_reg      <= '0;
            chan_cnt_reg <= '0;
            ctrl_cnt_reg <= '0;
        end
        else if (take)
        begin
            active_reg   <= active_next;
            dedup_reg    <= dedup_next;
            ptr_reg      <= ptr_next;
            chan_cnt_reg <= chan_cnt_next;
            ctrl_cnt_reg <= ctrl_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mcsr_back.sv
// Back end: owns the value and last-sent tables and carries out queued operations.
// Depends on mcsr_pkg and assert_macros.svh; reads mcsr_op_queue, feeds mcsr_res_queue.
`default_nettype none
`include "assert_macros.svh"

module mcsr_back
    import mcsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic op_empty,
    input  op_t       op_data,
    output logic      op_pop,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res_data,
    output logic      init_busy
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_WIPE = 2'd3;

    logic [7:0] stored_mem [TABLE_SIZE];
    logic [7:0] last_mem   [TABLE_SIZE];

    logic [1:0]            state_reg, state_next;
    logic [TABLE_BITS-1:0] wipe_cnt_reg, wipe_cnt_next;
    op_t                   hold_reg, hold_next;
    logic [7:0]            stored_rd_reg;
    logic [7:0]            last_rd_reg;

    logic                  rd_en;
    logic                  stored_we;
    logic [TABLE_BITS-1:0] stored_waddr;
    logic [7:0]            stored_wdata;
    logic                  last_we;
    logic [TABLE_BITS-1:0] last_waddr;
    logic [7:0]            last_wdata;
    logic                  wipe_last;
    logic                  emit;

    assign init_busy = (state_reg == ST_INIT);
    assign wipe_last = (wipe_cnt_reg == TABLE_BITS'(TABLE_SIZE - 1));
    assign emit      = !stored_rd_reg[7]
                       && !(hold_reg.dedup && (last_rd_reg == stored_rd_reg));

    always_comb
    begin
        state_next    = state_reg;
        wipe_cnt_next = wipe_cnt_reg;
        hold_next     = hold_reg;
        op_pop        = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        rd_en         = 1'b0;
        stored_we     = 1'b0;
        stored_waddr  = op_data.idx;
        stored_wdata  = {1'b0, op_data.value};
        last_we       = 1'b0;
        last_waddr    = op_data.idx;
        last_wdata    = {1'b0, op_data.value};

        case (state_reg)
            ST_INIT:
            begin
                // Sweep both tables to their reset contents
                stored_we     = 1'b1;
                stored_waddr  = wipe_cnt_reg;
                stored_wdata  = EMPTY_ENTRY;
                last_we       = 1'b1;
                last_waddr    = wipe_cnt_reg;
                last_wdata    = NO_VALUE_SENT;
                wipe_cnt_next = wipe_last ? '0 : wipe_cnt_reg + 1'b1;
                if (wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Take an operation only when its result has room
                if (!op_empty && !res_full)
                begin
                    op_pop = 1'b1;
                    case (op_data.kind)
                        OP_STORE:
                        begin
                            stored_we = 1'b1;
                            last_we   = op_data.wr_last;
                            res_push  = 1'b1;
                            res_data  = op_data.res;
                        end
                        OP_CHECK:
                        begin
                            rd_en      = 1'b1;
                            hold_next  = op_data;
                            state_next = ST_EVAL;
                        end
                        OP_CLEAR:
                        begin
                            hold_next     = op_data;
                            wipe_cnt_next = '0;
                            state_next    = ST_WIPE;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                            res_data = op_data.res;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                res_push = 1'b1;
                res_data = hold_reg.res;
                if (emit)
                begin
                    res_data.out_valid    = 1'b1;
                    res_data.from_replay  = 1'b1;
                    res_data.out_data_two = {1'b0, stored_rd_reg[6:0]};
                    last_we               = 1'b1;
                    last_waddr            = hold_reg.idx;
                    last_wdata            = stored_rd_reg;
                end
                else
                begin
                    res_data.out_valid    = 1'b0;
                    res_data.from_replay  = 1'b0;
                    res_data.out_status   = '0;
                    res_data.out_data_one = '0;
                    res_data.out_data_two = '0;
                end
                state_next = ST_IDLE;
            end
            ST_WIPE:
            begin
                stored_we     = 1'b1;
                stored_waddr  = wipe_cnt_reg;
                stored_wdata  = EMPTY_ENTRY;
                wipe_cnt_next = wipe_last ? '0 : wipe_cnt_reg + 1'b1;
                if (wipe_last)
                begin
                    res_push   = 1'b1;
                    res_data   = hold_reg.res;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            wipe_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wipe_cnt_reg <= wipe_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (stored_we)
        begin
            stored_mem[stored_waddr] <= stored_wdata;
        end
        if (rd_en)
        begin
            stored_rd_reg <= stored_mem[op_data.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_we)
        begin
            last_mem[last_waddr] <= last_wdata;
        end
        if (rd_en)
        begin
            last_rd_reg <= last_mem[op_data.idx];
        end
    end

    `ASSERT_IMP(a_eval_has_room, state_reg == ST_EVAL || (state_reg == ST_WIPE && wipe_last), !res_full)
    `ASSERT_NXT(a_check_enters_eval, op_pop && op_data.kind == OP_CHECK, state_reg == ST_EVAL)
    `ASSERT_IMP(a_init_is_silent, state_reg == ST_INIT, !op_pop && !res_push)
    `ASSERT_NXT(a_clear_enters_wipe, op_pop && op_data.kind == OP_CLEAR, state_reg == ST_WIPE && wipe_cnt_reg == '0)

endmodule

`default_nettype wire
